// ===== rtl/fmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmdc_pkg
// Types and constants for the four-motor drive command block.
// ----------------------------------------------------------------------------
package fmdc_pkg;

    localparam int SPEED_W    = 8;
    localparam int TIME_W     = 32;
    localparam int DUR_W      = 16;
    localparam int OP_W       = 4;
    localparam int IDX_W      = 2;
    localparam int NUM_MOTORS = 4;

    localparam logic [DUR_W-1:0] BRAKE_DURATION_RESET = 16'd100;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd127;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd127;
    localparam logic signed [SPEED_W-1:0] SPEED_RAW_MIN = -8'sd128;

    localparam logic [OP_W-1:0] OP_SET     = 4'd0;
    localparam logic [OP_W-1:0] OP_LEFT    = 4'd1;
    localparam logic [OP_W-1:0] OP_RIGHT   = 4'd2;
    localparam logic [OP_W-1:0] OP_BACK    = 4'd3;
    localparam logic [OP_W-1:0] OP_FORWARD = 4'd4;
    localparam logic [OP_W-1:0] OP_CW      = 4'd5;
    localparam logic [OP_W-1:0] OP_CCW     = 4'd6;
    localparam logic [OP_W-1:0] OP_STOP    = 4'd7;
    localparam logic [OP_W-1:0] OP_BRAKE   = 4'd8;
    localparam logic [OP_W-1:0] OP_APPLY   = 4'd9;

    localparam logic [IDX_W-1:0] IDX_LEFT  = 2'd0;
    localparam logic [IDX_W-1:0] IDX_RIGHT = 2'd1;
    localparam logic [IDX_W-1:0] IDX_FRONT = 2'd2;
    localparam logic [IDX_W-1:0] IDX_BACK  = 2'd3;

    typedef logic signed [SPEED_W-1:0] speed_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  motor_index;
        speed_t            speed_value;
        logic [TIME_W-1:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [7:0] duty_left;
        logic [7:0] duty_right;
        logic [7:0] duty_front;
        logic [7:0] duty_back;
        logic       fwd_left;
        logic       fwd_right;
        logic       fwd_front;
        logic       fwd_back;
        logic       brake_active;
    } rsp_t;

endpackage

// ===== rtl/four_motor_drive_command_brake_queue.sv =====
// ----------------------------------------------------------------------------
// four_motor_drive_command_brake_queue
// Four-motor speed command block with hard brake and queued moves.
// ----------------------------------------------------------------------------
// Commands are taken one per cycle while the channel is not stalled. Each
// accepted command lands in an input register and executes against the speed
// state when it leaves that register. The edge that executes an apply command
// also puts one duty/direction result in the output register, which offers it.
// Other commands produce no result. The command channel stalls only while an
// apply waits behind a result that the output side has not yet taken.
// brake_duration_ms may be written only while no command is in flight.
// ----------------------------------------------------------------------------
module four_motor_drive_command_brake_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  fmdc_pkg::cmd_t              cmd,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output fmdc_pkg::rsp_t              rsp,
    input  logic                        cfg_we,
    input  logic [fmdc_pkg::DUR_W-1:0]  cfg_wdata
);

    logic                         stage_valid_reg;
    fmdc_pkg::cmd_t               stage_reg;
    logic                         rsp_valid_reg;
    fmdc_pkg::rsp_t               rsp_reg;
    logic [fmdc_pkg::DUR_W-1:0]   duration_reg;
    fmdc_pkg::rsp_t               core_result;
    logic                         core_apply;
    logic                         out_free;
    logic                         stage_fire;
    logic                         cmd_take;

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign stage_fire = stage_valid_reg && (!core_apply || out_free);
    assign cmd_stall  = stage_valid_reg && !stage_fire;
    assign cmd_take   = cmd_valid && !cmd_stall;

    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    fmdc_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (stage_fire),
        .item              (stage_reg),
        .brake_duration_ms (duration_reg),
        .result            (core_result),
        .is_apply          (core_apply)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            duration_reg    <= fmdc_pkg::BRAKE_DURATION_RESET;
        end
        else
        begin
            if (cfg_we)
                duration_reg <= cfg_wdata;
            if (cmd_take || stage_fire)
                stage_valid_reg <= cmd_take;
            if (stage_fire && core_apply)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            stage_reg <= cmd;
        if (stage_fire && core_apply)
            rsp_reg <= core_result;
    end

    a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (stage_valid_reg && core_apply && rsp_valid_reg))
        else $error("stall without a blocked apply");

    a_apply_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && core_apply) |=> rsp_valid_reg)
        else $error("apply lost its result");

    a_no_result_from_other: assert property (@(posedge clk) disable iff (!rst_n)
        (!(stage_fire && core_apply) && rsp_valid_reg && !rsp_stall) |=> !rsp_valid_reg)
        else $error("result invented");

endmodule

// ===== rtl/fmdc_core.sv =====
// ----------------------------------------------------------------------------
// fmdc_core
// Speed, pending and brake state; executes one command per fire.
// ----------------------------------------------------------------------------
module fmdc_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  fmdc_pkg::cmd_t                   item,
    input  logic [fmdc_pkg::DUR_W-1:0]       brake_duration_ms,
    output fmdc_pkg::rsp_t                   result,
    output logic                             is_apply
);

    fmdc_pkg::speed_t speed_reg     [fmdc_pkg::NUM_MOTORS];
    fmdc_pkg::speed_t speed_next    [fmdc_pkg::NUM_MOTORS];
    fmdc_pkg::speed_t pending_reg   [fmdc_pkg::NUM_MOTORS];
    fmdc_pkg::speed_t pending_next  [fmdc_pkg::NUM_MOTORS];
    fmdc_pkg::speed_t mag           [fmdc_pkg::NUM_MOTORS];
    logic [7:0]       duty          [fmdc_pkg::NUM_MOTORS];
    logic             fwd           [fmdc_pkg::NUM_MOTORS];
    logic                            braking_reg, braking_next;
    logic                            pend_flag_reg, pend_flag_next;
    logic [fmdc_pkg::TIME_W-1:0]     start_reg, start_next;
    logic [fmdc_pkg::TIME_W-1:0]     elapsed;
    logic                            brake_done;
    fmdc_pkg::speed_t                v, nv;

    assign v  = (item.speed_value == fmdc_pkg::SPEED_RAW_MIN) ? fmdc_pkg::SPEED_MIN
                                                              : item.speed_value;
    assign nv = -v;

    assign elapsed    = item.now_ms - start_reg;
    assign brake_done = braking_reg &&
                        (elapsed > {{(fmdc_pkg::TIME_W-fmdc_pkg::DUR_W){1'b0}},
                                    brake_duration_ms});
    assign is_apply   = (item.op == fmdc_pkg::OP_APPLY);

    always_comb
    begin
        for (int i = 0; i < fmdc_pkg::NUM_MOTORS; i++)
        begin
            mag[i]  = speed_reg[i][fmdc_pkg::SPEED_W-1] ? -speed_reg[i] : speed_reg[i];
            duty[i] = {mag[i][fmdc_pkg::SPEED_W-2:0], 1'b0};
            fwd[i]  = !speed_reg[i][fmdc_pkg::SPEED_W-1] && (speed_reg[i] != '0);
        end
    end

    assign result.duty_left    = duty[fmdc_pkg::IDX_LEFT];
    assign result.duty_right   = duty[fmdc_pkg::IDX_RIGHT];
    assign result.duty_front   = duty[fmdc_pkg::IDX_FRONT];
    assign result.duty_back    = duty[fmdc_pkg::IDX_BACK];
    assign result.fwd_left     = fwd[fmdc_pkg::IDX_LEFT];
    assign result.fwd_right    = fwd[fmdc_pkg::IDX_RIGHT];
    assign result.fwd_front    = fwd[fmdc_pkg::IDX_FRONT];
    assign result.fwd_back     = fwd[fmdc_pkg::IDX_BACK];
    assign result.brake_active = braking_reg && !brake_done;

    always_comb
    begin
        speed_next     = speed_reg;
        pending_next   = pending_reg;
        braking_next   = braking_reg;
        pend_flag_next = pend_flag_reg;
        start_next     = start_reg;
        case (item.op)
            fmdc_pkg::OP_SET:
            begin
                speed_next[item.motor_index] = v;
            end
            fmdc_pkg::OP_LEFT, fmdc_pkg::OP_RIGHT:
            begin
                if (braking_reg)
                begin
                    pending_next[fmdc_pkg::IDX_FRONT] = (item.op == fmdc_pkg::OP_LEFT) ? nv : v;
                    pending_next[fmdc_pkg::IDX_BACK]  = (item.op == fmdc_pkg::OP_LEFT) ? nv : v;
                    pend_flag_next = 1'b1;
                end
                else
                begin
                    speed_next[fmdc_pkg::IDX_FRONT] = (item.op == fmdc_pkg::OP_LEFT) ? nv : v;
                    speed_next[fmdc_pkg::IDX_BACK]  = (item.op == fmdc_pkg::OP_LEFT) ? nv : v;
                end
            end
            fmdc_pkg::OP_BACK, fmdc_pkg::OP_FORWARD:
            begin
                if (braking_reg)
                begin
                    pending_next[fmdc_pkg::IDX_LEFT]  = (item.op == fmdc_pkg::OP_BACK) ? nv : v;
                    pending_next[fmdc_pkg::IDX_RIGHT] = (item.op == fmdc_pkg::OP_BACK) ? nv : v;
                    pend_flag_next = 1'b1;
                end
                else
                begin
                    speed_next[fmdc_pkg::IDX_LEFT]  = (item.op == fmdc_pkg::OP_BACK) ? nv : v;
                    speed_next[fmdc_pkg::IDX_RIGHT] = (item.op == fmdc_pkg::OP_BACK) ? nv : v;
                end
            end
            fmdc_pkg::OP_CW, fmdc_pkg::OP_CCW:
            begin
                speed_next[fmdc_pkg::IDX_LEFT]  = (item.op == fmdc_pkg::OP_CW) ? v : nv;
                speed_next[fmdc_pkg::IDX_FRONT] = (item.op == fmdc_pkg::OP_CW) ? v : nv;
                speed_next[fmdc_pkg::IDX_RIGHT] = (item.op == fmdc_pkg::OP_CW) ? nv : v;
                speed_next[fmdc_pkg::IDX_BACK]  = (item.op == fmdc_pkg::OP_CW) ? nv : v;
            end
            fmdc_pkg::OP_STOP:
            begin
                for (int i = 0; i < fmdc_pkg::NUM_MOTORS; i++)
                    speed_next[i] = '0;
            end
            fmdc_pkg::OP_BRAKE:
            begin
                for (int i = 0; i < fmdc_pkg::NUM_MOTORS; i++)
                    speed_next[i] = -speed_reg[i];
                start_next   = item.now_ms;
                braking_next = 1'b1;
            end
            fmdc_pkg::OP_APPLY:
            begin
                if (brake_done)
                begin
                    braking_next   = 1'b0;
                    pend_flag_next = 1'b0;
                    for (int i = 0; i < fmdc_pkg::NUM_MOTORS; i++)
                        speed_next[i] = pend_flag_reg ? pending_reg[i] : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fmdc_pkg::NUM_MOTORS; i++)
            begin
                speed_reg[i]   <= '0;
                pending_reg[i] <= '0;
            end
            braking_reg   <= 1'b0;
            pend_flag_reg <= 1'b0;
            start_reg     <= '0;
        end
        else if (fire)
        begin
            speed_reg     <= speed_next;
            pending_reg   <= pending_next;
            braking_reg   <= braking_next;
            pend_flag_reg <= pend_flag_next;
            start_reg     <= start_next;
        end
    end

    a_brake_ends_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (braking_reg == 1'b0) && (item.op != fmdc_pkg::OP_BRAKE)) |=> !braking_reg)
        else $error("braking set without brake command");

    a_fell_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && braking_reg && !is_apply) |=> braking_reg)
        else $error("brake ended outside apply");

    a_pending_clear_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_apply && brake_done) |=> !pend_flag_reg)
        else $error("pending set not consumed at brake end");

endmodule

// ===== bench/motor_duty_checker.sv =====
// ----------------------------------------------------------------------------
// motor_duty_checker
// Watches the command, result and brake-length ports of the four-motor drive
// block. It keeps its own copy of the motor speeds, the queued move set and
// the brake timer, and works out the duty report of every apply command. Each
// report taken from the block is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module motor_duty_checker
    import fmdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  cmd_t              cmd,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [DUR_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    speed_t             speed_now    [NUM_MOTORS];
    speed_t             speed_queued [NUM_MOTORS];
    logic               braking;
    logic               queued_valid;
    logic [TIME_W-1:0]  brake_t0;
    logic [DUR_W-1:0]   brake_len;
    rsp_t               report_q [$];

    function automatic speed_t limit_speed(input speed_t v);
        return (v == SPEED_RAW_MIN) ? SPEED_MIN : v;
    endfunction

    function automatic logic [7:0] duty_of(input speed_t s);
        speed_t mag;
        mag = (s < 0) ? -s : s;
        return {mag[6:0], 1'b0};
    endfunction

    function automatic void move_pair(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                                      input speed_t v);
        if (braking)
        begin
            speed_queued[a] = v;
            speed_queued[b] = v;
            queued_valid = 1'b1;
        end
        else
        begin
            speed_now[a] = v;
            speed_now[b] = v;
        end
    endfunction

    function automatic void spin(input speed_t v);
        speed_now[IDX_LEFT]  = v;
        speed_now[IDX_FRONT] = v;
        speed_now[IDX_RIGHT] = -v;
        speed_now[IDX_BACK]  = -v;
    endfunction

    function automatic void run_command(input cmd_t c);
        speed_t v;
        rsp_t   r;
        v = limit_speed(c.speed_value);
        case (c.op)
            OP_SET:     speed_now[c.motor_index] = v;
            OP_LEFT:    move_pair(IDX_FRONT, IDX_BACK, -v);
            OP_RIGHT:   move_pair(IDX_FRONT, IDX_BACK, v);
            OP_BACK:    move_pair(IDX_LEFT, IDX_RIGHT, -v);
            OP_FORWARD: move_pair(IDX_LEFT, IDX_RIGHT, v);
            OP_CW:      spin(v);
            OP_CCW:     spin(-v);
            OP_STOP:
            begin
                foreach (speed_now[i])
                    speed_now[i] = '0;
            end
            OP_BRAKE:
            begin
                foreach (speed_now[i])
                    speed_now[i] = -speed_now[i];
                brake_t0 = c.now_ms;
                braking  = 1'b1;
            end
            OP_APPLY:
            begin
                r.duty_left  = duty_of(speed_now[IDX_LEFT]);
                r.duty_right = duty_of(speed_now[IDX_RIGHT]);
                r.duty_front = duty_of(speed_now[IDX_FRONT]);
                r.duty_back  = duty_of(speed_now[IDX_BACK]);
                r.fwd_left   = speed_now[IDX_LEFT] > 0;
                r.fwd_right  = speed_now[IDX_RIGHT] > 0;
                r.fwd_front  = speed_now[IDX_FRONT] > 0;
                r.fwd_back   = speed_now[IDX_BACK] > 0;
                if (braking && (c.now_ms - brake_t0) > brake_len)
                begin
                    braking = 1'b0;
                    foreach (speed_now[i])
                        speed_now[i] = queued_valid ? speed_queued[i] : '0;
                    queued_valid = 1'b0;
                end
                r.brake_active = braking;
                report_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_report(input rsp_t got);
        rsp_t want;
        if (report_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected duty report %h at %0t", got, $time);
            return;
        end
        want = report_q.pop_front();
        if (got.duty_left !== want.duty_left || got.duty_right !== want.duty_right ||
            got.duty_front !== want.duty_front || got.duty_back !== want.duty_back ||
            got.fwd_left !== want.fwd_left || got.fwd_right !== want.fwd_right ||
            got.fwd_front !== want.fwd_front || got.fwd_back !== want.fwd_back ||
            got.brake_active !== want.brake_active)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("duty report mismatch at %0t", $time);
                $display("  expected duty %0d %0d %0d %0d fwd %b%b%b%b brake %b",
                         want.duty_left, want.duty_right, want.duty_front, want.duty_back,
                         want.fwd_left, want.fwd_right, want.fwd_front, want.fwd_back,
                         want.brake_active);
                $display("  actual   duty %0d %0d %0d %0d fwd %b%b%b%b brake %b",
                         got.duty_left, got.duty_right, got.duty_front, got.duty_back,
                         got.fwd_left, got.fwd_right, got.fwd_front, got.fwd_back,
                         got.brake_active);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (speed_now[i])
            begin
                speed_now[i]    = '0;
                speed_queued[i] = '0;
            end
            braking      = 1'b0;
            queued_valid = 1'b0;
            brake_t0     = '0;
            brake_len    = BRAKE_DURATION_RESET;
            report_q.delete();
            fail_count   = 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
                brake_len = cfg_wdata;
            if (rsp_valid && !rsp_stall)
                check_report(rsp);
            if (cmd_valid && !cmd_stall)
                run_command(cmd);
            pending_results <= report_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the four-motor drive block: a directed run through every
// command, clamping, queued moves under a hard brake and the brake timer edge,
// then random command streams under several brake lengths, with random idle
// bursts on both channels, one long result hold-off and a checker alongside.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmdc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam speed_t CORNER_SPEEDS [6] = '{-8'sd128, -8'sd127, 8'sd127, 8'sd0, -8'sd1, 8'sd1};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    cmd_t              cmd;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp;
    logic              cfg_we;
    logic [DUR_W-1:0]  cfg_wdata;

    int                fail_count;
    int                pending_results;
    int                cycle_count = 0;
    bit                idle_on;
    bit                rsp_hold;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] last_brake_ms;
    logic [DUR_W-1:0]  brake_len;

    four_motor_drive_command_brake_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    motor_duty_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                rsp_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic send(input cmd_t c);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (c.op == OP_BRAKE)
            last_brake_ms = c.now_ms;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input speed_t v, input logic [TIME_W-1:0] t);
        cmd_t c;
        c.op          = op;
        c.motor_index = idx;
        c.speed_value = v;
        c.now_ms      = t;
        send(c);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic write_brake_len(input logic [DUR_W-1:0] d);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        brake_len = d;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item(output bit useful);
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 22)
            c.op = OP_APPLY;
        else if (r < 30)
            c.op = OP_BRAKE;
        else if (r < 34)
            c.op = OP_STOP;
        else if (r < 38)
            c.op = OP_W'($urandom_range(OP_APPLY + 1, {OP_W{1'b1}}));
        else
            c.op = OP_W'($urandom_range(OP_SET, OP_CCW));
        useful = (c.op <= OP_APPLY);
        c.motor_index = IDX_W'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0)
            c.speed_value = CORNER_SPEEDS[$urandom_range(0, 5)];
        else
            c.speed_value = SPEED_W'($urandom_range(0, 255));
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else if (c.op == OP_APPLY && $urandom_range(0, 9) == 0)
            clock_ms = last_brake_ms + brake_len + $urandom_range(0, 1);
        else
            clock_ms = clock_ms + $urandom_range(0, brake_len / 4 + 3);
        c.now_ms = clock_ms;
        send(c);
    endtask

    initial
    begin
        logic [DUR_W-1:0] phase_len [5];
        bit               useful;
        int               n;

        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        idle_on       = 1'b1;
        rsp_hold      = 1'b0;
        clock_ms      = '0;
        last_brake_ms = '0;
        brake_len     = BRAKE_DURATION_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_SET, IDX_LEFT, SPEED_MAX, 32'd0);
        send_op(OP_SET, IDX_RIGHT, SPEED_RAW_MIN, 32'd0);
        send_op(OP_SET, IDX_FRONT, SPEED_MIN, 32'd0);
        send_op(OP_SET, IDX_BACK, 8'sd1, 32'd0);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'd0);
        send_op(OP_LEFT, IDX_LEFT, 8'sd55, 32'd1);
        send_op(OP_BACK, IDX_RIGHT, SPEED_RAW_MIN, 32'd2);
        send_op(OP_APPLY, IDX_FRONT, 8'sd0, 32'd3);
        send_op(OP_CW, IDX_BACK, -8'sd100, 32'd4);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'd5);
        send_op(OP_CCW, IDX_LEFT, SPEED_MAX, 32'd6);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'd7);
        send_op(OP_W'(OP_APPLY + 1), IDX_BACK, SPEED_MAX, 32'hFFFF_FFFF);
        send_op({OP_W{1'b1}}, IDX_BACK, SPEED_RAW_MIN, 32'hFFFF_FFFF);
        send_op(OP_BRAKE, IDX_LEFT, 8'sd0, 32'hFFFF_FFF0);
        send_op(OP_RIGHT, IDX_LEFT, 8'sd33, 32'hFFFF_FFF1);
        send_op(OP_FORWARD, IDX_LEFT, SPEED_RAW_MIN, 32'hFFFF_FFF2);
        send_op(OP_BRAKE, IDX_LEFT, 8'sd0, 32'hFFFF_FFF8);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'h0000_005C);
        send_op(OP_STOP, IDX_LEFT, 8'sd0, 32'h0000_005C);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'h0000_005D);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'hFFFF_FFFF);
        send_op(OP_SET, IDX_BACK, -8'sd64, 32'd0);
        send_op(OP_APPLY, IDX_LEFT, 8'sd0, 32'd0);

        phase_len = '{16'd0, 16'hFFFF, DUR_W'($urandom_range(1, 60)), 16'd1,
                      DUR_W'($urandom_range(0, 65535))};
        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
                idle_on = 1'b0;
            write_brake_len(phase_len[p]);
            if (p == 2)
            begin
                rsp_hold = 1'b1;
                repeat (60) random_item(useful);
            end
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                random_item(useful);
                if (useful)
                begin
                    n++;
                    if (p == 1 && n == 60)
                        drain();
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
